// ----- rtl/brcc_pkg.sv -----
// Shared constants for the boot region checksum checker.
`timescale 1ns / 1ps

package brcc_pkg;

    // Default sector size in bytes.
    localparam int SECTOR_BYTES_DEF = 512;

    // Sectors in one boot region; the last one carries the stored checksum.
    localparam int REGION_SECTORS = 12;

    // Width of a data beat and of a checksum.
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 32;

    // Region byte offsets excluded from the checksum (volume flags and percent in use).
    localparam int SKIP_FLAGS_LO = 106;
    localparam int SKIP_FLAGS_HI = 107;
    localparam int SKIP_PERCENT  = 112;

    // Bytes of the stored little-endian checksum word.
    localparam int WORD_BYTES = 4;

endpackage

// ----- rtl/boot_region_checksum_check_core.sv -----
// Boot region checksum checker: one byte per cycle when not stalled, main and backup.
`timescale 1ns / 1ps

// Bytes of a main boot region and then of its backup stream in at one beat per clock
// cycle. Each region is 12 sectors of SECTOR_BYTES bytes; the first 11 sectors feed a
// rotate-right-and-add checksum (region offsets 106, 107 and 112 skipped) and the first
// four bytes of sector 11 form the stored little-endian checksum. After the last byte of
// each region one result beat appears: the byte sits in an input register, then the
// rotate-add and compare fill the result register.
// The sustained rate is one byte per cycle, set by the single 32-bit rotate-add per
// byte; input ready drops only while a finished result waits and the next result is due.
// A byte with region_start high drops all progress and counts as main region offset 0.
module boot_region_checksum_check_core #(
    parameter int SECTOR_BYTES = brcc_pkg::SECTOR_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Byte stream in
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [brcc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_region_start,
    // Result out
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [brcc_pkg::SUM_W-1:0] o_computed_checksum,
    output logic [brcc_pkg::SUM_W-1:0] o_stored_checksum,
    output logic                       o_region_ok,
    output logic                       o_is_backup,
    output logic                       o_both_ok
);

    localparam int REGION_BYTES = brcc_pkg::REGION_SECTORS * SECTOR_BYTES;
    localparam int SUM_BYTES    = (brcc_pkg::REGION_SECTORS - 1) * SECTOR_BYTES;
    localparam int POS_W        = $clog2(REGION_BYTES);
    localparam int SW           = brcc_pkg::SUM_W;
    localparam int BW           = brcc_pkg::BYTE_W;

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(REGION_BYTES - 1);
    localparam logic [POS_W-1:0] POS_SUM_END = POS_W'(SUM_BYTES);
    localparam logic [POS_W-1:0] POS_WORD_END = POS_W'(SUM_BYTES + brcc_pkg::WORD_BYTES);
    localparam logic [POS_W-1:0] POS_SKIP_A  = POS_W'(brcc_pkg::SKIP_FLAGS_LO);
    localparam logic [POS_W-1:0] POS_SKIP_B  = POS_W'(brcc_pkg::SKIP_FLAGS_HI);
    localparam logic [POS_W-1:0] POS_SKIP_C  = POS_W'(brcc_pkg::SKIP_PERCENT);

    // Input stage
    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_start;

    // Region state
    logic [POS_W-1:0] r_pos,       n_pos;
    logic [SW-1:0]    r_sum,       n_sum;
    logic [SW-1:0]    r_word,      n_word;
    logic [SW-1:0]    r_main_sum,  n_main_sum;
    logic             r_main_good, n_main_good;
    logic             r_backup,    n_backup;

    // Result register
    logic          r_out_valid;
    logic [SW-1:0] r_out_computed;
    logic [SW-1:0] r_out_stored;
    logic          r_out_ok;
    logic          r_out_backup;
    logic          r_out_both;

    // Working values for the byte in the input stage
    logic [POS_W-1:0] w_pos;
    logic [SW-1:0]    w_sum;
    logic [SW-1:0]    w_word;
    logic [SW-1:0]    w_main_sum;
    logic             w_main_good;
    logic             w_backup;
    logic [SW-1:0]    w_new_sum;
    logic [SW-1:0]    w_new_word;
    logic [1:0]       w_word_lane;
    logic             w_last;
    logic             w_ok;
    logic             w_both;
    logic             w_out_free;
    logic             w_advance;
    logic             w_emit;

    // Handshake: a beat leaves the input stage unless its result has nowhere to go.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_last || w_out_free);
    assign w_emit     = w_advance && w_last;
    assign o_in_ready = !r_in_valid || w_advance;

    // Effective state: a region start behaves as a fresh reset.
    assign w_pos       = r_in_start ? '0   : r_pos;
    assign w_sum       = r_in_start ? '0   : r_sum;
    assign w_word      = r_in_start ? '0   : r_word;
    assign w_main_sum  = r_in_start ? '0   : r_main_sum;
    assign w_main_good = r_in_start ? 1'b0 : r_main_good;
    assign w_backup    = r_in_start ? 1'b0 : r_backup;

    assign w_word_lane = w_pos[1:0];
    assign w_last      = (w_pos == POS_LAST);

    // Checksum update and stored word capture.
    always_comb begin
        w_new_sum  = w_sum;
        w_new_word = w_word;
        if (w_pos < POS_SUM_END) begin
            if (w_pos != POS_SKIP_A && w_pos != POS_SKIP_B && w_pos != POS_SKIP_C) begin
                w_new_sum = {w_sum[0], w_sum[SW-1:1]} + SW'(r_in_byte);
            end
        end else if (w_pos < POS_WORD_END) begin
            w_new_word = w_word | (SW'(r_in_byte) << {w_word_lane, 3'b000});
        end
    end

    assign w_ok   = (w_new_sum == w_new_word);
    assign w_both = w_main_good && w_ok && (w_main_sum == w_new_sum);

    // Next region state.
    always_comb begin
        n_pos       = w_pos + POS_W'(1);
        n_sum       = w_new_sum;
        n_word      = w_new_word;
        n_main_sum  = w_main_sum;
        n_main_good = w_main_good;
        n_backup    = w_backup;
        if (w_last) begin
            n_pos  = '0;
            n_sum  = '0;
            n_word = '0;
            if (!w_backup) begin
                n_main_sum  = w_new_sum;
                n_main_good = w_ok;
                n_backup    = 1'b1;
            end else begin
                n_main_sum  = '0;
                n_main_good = 1'b0;
                n_backup    = 1'b0;
            end
        end
    end

    // Input stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_region_start;
        end
    end

    // Region state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_word      <= '0;
            r_main_sum  <= '0;
            r_main_good <= 1'b0;
            r_backup    <= 1'b0;
        end else if (w_advance) begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_word      <= n_word;
            r_main_sum  <= n_main_sum;
            r_main_good <= n_main_good;
            r_backup    <= n_backup;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_computed <= w_new_sum;
            r_out_stored   <= w_new_word;
            r_out_ok       <= w_ok;
            r_out_backup   <= w_backup;
            r_out_both     <= w_backup && w_both;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_computed_checksum = r_out_computed;
    assign o_stored_checksum   = r_out_stored;
    assign o_region_ok         = r_out_ok;
    assign o_is_backup         = r_out_backup;
    assign o_both_ok           = r_out_both;

    // The byte position always stays inside one region.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position ran past the region end");

    // A result beat clears the region progress for the next region.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_pos == '0 && r_sum == '0 && r_word == '0))
        else $error("region state not cleared after result");

    // The phase flips on every result beat.
    a_phase_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_backup == !$past(w_backup)))
        else $error("region phase did not toggle on result");

    // A main region result never claims both regions agree.
    a_main_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_backup) |-> !r_out_both)
        else $error("both_ok set on a main region result");

    // Agreement of both regions implies this region checks.
    a_both_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_both) |-> r_out_ok)
        else $error("both_ok set without region_ok");

endmodule
